>>> design/pme_pkg.sv
// ----------------------------------------------------------------------------
// pme_pkg - shared types and constants for the permutation mutation engine
// Request and response payloads, action codes and fixed widths.
// ----------------------------------------------------------------------------
package pme_pkg;

  localparam int FIELD_W        = 5;   // width of every request field but action
  localparam int VAL_W          = 5;   // width of one stored city index
  localparam int POS_W          = 6;   // working width of positions and counts
  localparam int CNT_W          = 6;   // city_count register width
  localparam int DEF_MAX_CITIES = 32;
  localparam int MIN_CITIES     = 4;

  localparam logic [CNT_W-1:0] CITY_COUNT_RST = 6'd30;

  localparam logic [2:0] ACT_LOAD    = 3'd0;
  localparam logic [2:0] ACT_READ    = 3'd1;
  localparam logic [2:0] ACT_SWAP    = 3'd2;
  localparam logic [2:0] ACT_ROTATE  = 3'd3;
  localparam logic [2:0] ACT_BLOCK   = 3'd4;
  localparam logic [2:0] ACT_REVERSE = 3'd5;

  typedef struct packed {
    logic [2:0]         action;
    logic [FIELD_W-1:0] pos_a;
    logic [FIELD_W-1:0] pos_b;
    logic [FIELD_W-1:0] amount;
    logic [FIELD_W-1:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             status;
  } rsp_t;

endpackage

>>> design/permutation_mutation_engine_top.sv
// ----------------------------------------------------------------------------
// permutation_mutation_engine_top - permutation store with mutation operators
// Keeps a permutation of city indices and applies load, read, swap, rotate,
// block exchange and wrapping segment reversal, one request at a time.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake               payload
//   -------   ---   ---------------------   -----------------------------------
//   cmd       in    cmd_valid / cmd_ready   pme_pkg::cmd_t  (one request)
//   rsp       out   rsp_valid / rsp_ready   pme_pkg::rsp_t  (entry at pos_a, status)
//   cfg       in    cfg_valid / cfg_ready   city_count, 6 bits, always ready
//
// From request taken to response valid the sequencer reduces positions modulo
// the active count, sets up, runs the block range check for block requests,
// a setup step per reversal pass and the swaps, then the final read and the
// result load; it passes through idle before the next request is taken.
// Every swap costs a dual read then two writes through the store's single
// write port; rotate right by k is done as three reversals (whole, first k,
// remainder).
// After reset the store is refilled with the identity, one entry a cycle, with
// cmd_ready low; cfg writes are taken throughout.
// The response register lets the next request in while a response stalls;
// the sequencer waits on a full response register only at its last step.
//
module permutation_mutation_engine_top #(
  parameter int MAX_CITIES = pme_pkg::DEF_MAX_CITIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  pme_pkg::cmd_t             cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output pme_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pme_pkg::CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_CITIES);

  logic [pme_pkg::CNT_W-1:0] city_count;

  // result hand-off from the sequencer
  logic          rsp_free;
  logic          res_load;
  pme_pkg::rsp_t res;

  // store ports
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [pme_pkg::VAL_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr0;
  logic [AW-1:0]             mem_raddr1;
  logic [pme_pkg::VAL_W-1:0] mem_rdata0;
  logic [pme_pkg::VAL_W-1:0] mem_rdata1;

  // configuration: one register, never back-pressured
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= pme_pkg::CITY_COUNT_RST;
    end else if (cfg_valid) begin
      city_count <= cfg_data;
    end
  end

  // response register: free when empty or being drained this cycle
  assign rsp_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

  pme_seq #(
    .MAX_CITIES (MAX_CITIES),
    .AW         (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready),
    .city_count (city_count),
    .rsp_free   (rsp_free),
    .res_load   (res_load),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr0 (mem_raddr0),
    .mem_raddr1 (mem_raddr1),
    .mem_rdata0 (mem_rdata0),
    .mem_rdata1 (mem_rdata1)
  );

  pme_store #(
    .MAX_CITIES (MAX_CITIES),
    .AW         (AW)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

  // a taken request keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd_ready high straight after a request was taken");

  // the identity refill must run before any request is taken
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !cmd_ready)
    else $error("request accepted before the store refill");

  // an idle sequencer never disturbs the store
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !mem_we)
    else $error("store written while idle");

endmodule

>>> design/pme_store.sv
// ----------------------------------------------------------------------------
// pme_store - permutation store
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module pme_store #(
  parameter int MAX_CITIES = pme_pkg::DEF_MAX_CITIES,
  parameter int AW         = $clog2(MAX_CITIES)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pme_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr0,
  input  logic [AW-1:0]             raddr1,
  output logic [pme_pkg::VAL_W-1:0] rdata0,
  output logic [pme_pkg::VAL_W-1:0] rdata1
);

  logic [pme_pkg::VAL_W-1:0] mem [MAX_CITIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> design/pme_seq.sv
// ----------------------------------------------------------------------------
// pme_seq - operation sequencer
// Reduces positions, checks parameters and runs every request that moves
// entries as a series of read / write / write swaps. Rotate is three reversals.
// ----------------------------------------------------------------------------
module pme_seq #(
  parameter int MAX_CITIES = pme_pkg::DEF_MAX_CITIES,
  parameter int AW         = $clog2(MAX_CITIES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  pme_pkg::cmd_t             cmd,
  output logic                      cmd_ready,
  input  logic [pme_pkg::CNT_W-1:0] city_count,
  input  logic                      rsp_free,
  output logic                      res_load,
  output pme_pkg::rsp_t             res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [pme_pkg::VAL_W-1:0] mem_wdata,
  output logic [AW-1:0]             mem_raddr0,
  output logic [AW-1:0]             mem_raddr1,
  input  logic [pme_pkg::VAL_W-1:0] mem_rdata0,
  input  logic [pme_pkg::VAL_W-1:0] mem_rdata1
);

  localparam int PW   = pme_pkg::POS_W;
  localparam int VW   = pme_pkg::VAL_W;
  localparam int NMAX = (MAX_CITIES > 63) ? 63 : MAX_CITIES;
  localparam logic [PW-1:0] NMAX_P = PW'(NMAX);
  localparam logic [PW-1:0] NMIN_P = PW'(pme_pkg::MIN_CITIES);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_CITIES - 1);
  localparam logic [1:0]    LAST_PASS = 2'd2;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MOD      = 4'd2;
  localparam logic [3:0] S_SETUP    = 4'd3;
  localparam logic [3:0] S_BLK_CHK  = 4'd4;
  localparam logic [3:0] S_REV_INIT = 4'd5;
  localparam logic [3:0] S_SW_RD    = 4'd6;
  localparam logic [3:0] S_SW_WP    = 4'd7;
  localparam logic [3:0] S_SW_WQ    = 4'd8;
  localparam logic [3:0] S_FINAL    = 4'd9;
  localparam logic [3:0] S_RESULT   = 4'd10;

  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;
  pme_pkg::cmd_t op;
  logic [PW-1:0] n, ia, ib, p, q;
  logic [4:0]    cnt;
  logic [VW-1:0] hold;
  logic          status, is_rot, blk;
  logic [1:0]    pass;
  logic [9:0]    prod_a, prod_b;

  logic [PW-1:0] n_act;
  logic [PW-1:0] seg_start, seg_len, seg_q;
  logic [PW:0]   seg_end;
  logic [PW-1:0] p_step, q_step;
  logic          blk_bad;

  // active count, saturated to the legal range
  always_comb begin
    if (city_count < NMIN_P) begin
      n_act = NMIN_P;
    end else if (city_count > NMAX_P) begin
      n_act = NMAX_P;
    end else begin
      n_act = city_count;
    end
  end

  // segment of the current reversal pass
  always_comb begin
    seg_start = ia;
    seg_len   = PW'(op.amount);
    if (is_rot) begin
      case (pass)
        2'd0: begin
          seg_start = '0;
          seg_len   = n;
        end
        2'd1: begin
          seg_start = '0;
          seg_len   = PW'(op.amount);
        end
        default: begin
          seg_start = PW'(op.amount);
          seg_len   = n - PW'(op.amount);
        end
      endcase
    end
    seg_end = (PW+1)'(seg_start) + (PW+1)'(seg_len) - (PW+1)'(1);
    seg_q   = (seg_end >= (PW+1)'(n)) ? PW'(seg_end - (PW+1)'(n)) : PW'(seg_end);
  end

  // pointer stepping: blocks walk forwards, reversals close in with wrap
  always_comb begin
    if (blk) begin
      p_step = p + 1'b1;
      q_step = q + 1'b1;
    end else begin
      p_step = (p + 1'b1 == n) ? '0 : p + 1'b1;
      q_step = (q == '0) ? n - 1'b1 : q - 1'b1;
    end
  end

  assign blk_bad = (op.amount == '0)
                || (11'(prod_a) + 11'(op.amount) > 11'(n))
                || (11'(prod_b) + 11'(op.amount) > 11'(n));

  assign cmd_ready = (state == S_IDLE);
  assign res_load  = (state == S_RESULT) && rsp_free;
  assign res       = '{read_value: mem_rdata0, status: status};

  assign mem_raddr0 = (state == S_SW_RD) ? AW'(p) : AW'(ia);
  assign mem_raddr1 = AW'(q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(p);
    mem_wdata = mem_rdata1;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = VW'(clr_cnt);
      end
      S_SETUP: begin
        mem_we    = (op.action == pme_pkg::ACT_LOAD);
        mem_waddr = AW'(ia);
        mem_wdata = op.load_value;
      end
      S_SW_WP: begin
        mem_we = 1'b1;
      end
      S_SW_WQ: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(q);
        mem_wdata = hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op    <= cmd;
            ia    <= PW'(cmd.pos_a);
            ib    <= PW'(cmd.pos_b);
            n     <= n_act;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (ia >= n) begin
            ia <= ia - n;
          end
          if (ib >= n) begin
            ib <= ib - n;
          end
          if (ia < n && ib < n) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          status <= 1'b0;
          is_rot <= 1'b0;
          pass   <= '0;
          blk    <= 1'b0;
          unique case (op.action) inside
            pme_pkg::ACT_LOAD, pme_pkg::ACT_READ: begin
              state <= S_FINAL;
            end
            pme_pkg::ACT_SWAP: begin
              p     <= ia;
              q     <= ib;
              cnt   <= 5'd1;
              state <= S_SW_RD;
            end
            pme_pkg::ACT_ROTATE: begin
              if (PW'(op.amount) >= n) begin
                status <= 1'b1;
                state  <= S_FINAL;
              end else if (op.amount == '0) begin
                state <= S_FINAL;
              end else begin
                is_rot <= 1'b1;
                state  <= S_REV_INIT;
              end
            end
            pme_pkg::ACT_BLOCK: begin
              prod_a <= 10'(op.pos_a) * 10'(op.amount);
              prod_b <= 10'(op.pos_b) * 10'(op.amount);
              state  <= S_BLK_CHK;
            end
            pme_pkg::ACT_REVERSE: begin
              if (PW'(op.amount) > n) begin
                status <= 1'b1;
                state  <= S_FINAL;
              end else begin
                state <= S_REV_INIT;
              end
            end
            default: begin
              status <= 1'b1;
              state  <= S_FINAL;
            end
          endcase
        end
        S_BLK_CHK: begin
          if (blk_bad) begin
            status <= 1'b1;
            state  <= S_FINAL;
          end else if (op.pos_a == op.pos_b) begin
            state <= S_FINAL;
          end else begin
            p     <= PW'(prod_a);
            q     <= PW'(prod_b);
            cnt   <= op.amount;
            blk   <= 1'b1;
            state <= S_SW_RD;
          end
        end
        S_REV_INIT: begin
          if (seg_len < PW'(2)) begin
            if (is_rot && pass != LAST_PASS) begin
              pass <= pass + 1'b1;
            end else begin
              state <= S_FINAL;
            end
          end else begin
            p     <= seg_start;
            q     <= seg_q;
            cnt   <= seg_len[PW-1:1];
            state <= S_SW_RD;
          end
        end
        S_SW_RD: begin
          state <= S_SW_WP;
        end
        S_SW_WP: begin
          hold  <= mem_rdata0;
          state <= S_SW_WQ;
        end
        S_SW_WQ: begin
          cnt <= cnt - 1'b1;
          p   <= p_step;
          q   <= q_step;
          if (cnt != 5'd1) begin
            state <= S_SW_RD;
          end else if (is_rot && pass != LAST_PASS) begin
            pass  <= pass + 1'b1;
            state <= S_REV_INIT;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/sv/tb_permutation_mutation_engine_top.sv
// ----------------------------------------------------------------------------
// tb_permutation_mutation_engine_top - self-checking bench for the engine
// Streams directed and random mutation requests at several city counts,
// mirrors the permutation store in a local predictor and checks each
// response in order, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_permutation_mutation_engine_top;

  // Action codes the block does not implement; both must be flagged.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  localparam int ITEMS_PER_COUNT = 225;
  localparam int SETTLE_CYCLES   = 200;
  localparam int FW              = pme_pkg::FIELD_W;
  localparam int CW              = pme_pkg::CNT_W;
  localparam int VW              = pme_pkg::VAL_W;
  localparam int NCITIES         = pme_pkg::DEF_MAX_CITIES;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  pme_pkg::cmd_t cmd = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  pme_pkg::rsp_t rsp;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CW-1:0] cfg_data = '0;

  permutation_mutation_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run: ~2.1k requests, each at
  // its slowest in the engine, plus receiver stalls and sender gaps.
  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Local copy of the engine: store contents and the city_count register.
  // --------------------------------------------------------------------------
  logic [VW-1:0] perm_model [NCITIES];
  logic [CW-1:0] model_count;

  pme_pkg::cmd_t pending_cmds [$];   // requests still to be offered
  pme_pkg::rsp_t expected_rsp [$];   // responses owed by the engine, oldest first

  int error_count    = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int count_settings = 1;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Active entry count: the register saturated into the supported range.
  function automatic int active_cities(input logic [CW-1:0] cnt);
    if (cnt < pme_pkg::MIN_CITIES) return pme_pkg::MIN_CITIES;
    if (cnt > NCITIES) return NCITIES;
    return int'(cnt);
  endfunction

  // Applies one request to the local store and returns the response owed.
  function automatic pme_pkg::rsp_t apply_mutation(input pme_pkg::cmd_t c);
    int n, pa, pb, amt, ia, ib, p, q;
    logic [VW-1:0] t;
    logic [VW-1:0] rotated [NCITIES];
    pme_pkg::rsp_t r;
    n   = active_cities(model_count);
    pa  = int'(c.pos_a);
    pb  = int'(c.pos_b);
    amt = int'(c.amount);
    ia  = pa % n;
    ib  = pb % n;
    r.status = 1'b0;
    case (c.action)
      pme_pkg::ACT_LOAD: perm_model[ia] = c.load_value;
      pme_pkg::ACT_READ: ;
      pme_pkg::ACT_SWAP: begin
        t              = perm_model[ia];
        perm_model[ia] = perm_model[ib];
        perm_model[ib] = t;
      end
      pme_pkg::ACT_ROTATE: begin
        if (amt >= n) begin
          r.status = 1'b1;
        end else if (amt != 0) begin
          for (int i = 0; i < n; i++) rotated[i] = perm_model[(i + n - amt) % n];
          for (int i = 0; i < n; i++) perm_model[i] = rotated[i];
        end
      end
      pme_pkg::ACT_BLOCK: begin
        // block numbers are not reduced; both blocks must sit inside n
        if (amt == 0 || pa * amt + amt > n || pb * amt + amt > n) begin
          r.status = 1'b1;
        end else if (pa != pb) begin
          for (int i = 0; i < amt; i++) begin
            p             = pa * amt + i;
            q             = pb * amt + i;
            t             = perm_model[p];
            perm_model[p] = perm_model[q];
            perm_model[q] = t;
          end
        end
      end
      pme_pkg::ACT_REVERSE: begin
        if (amt > n) begin
          r.status = 1'b1;
        end else begin
          // segment may run past entry n-1 and wrap to entry 0
          for (int i = 0; i < amt / 2; i++) begin
            p             = (ia + i) % n;
            q             = (ia + amt - 1 - i) % n;
            t             = perm_model[p];
            perm_model[p] = perm_model[q];
            perm_model[q] = t;
          end
        end
      end
      default: r.status = 1'b1;
    endcase
    r.read_value = perm_model[ia];
    return r;
  endfunction

  // Random request, mostly in range for the active count n so that the
  // rotate, block and reverse paths really move data; some pure noise.
  function automatic pme_pkg::cmd_t random_mutation(input int n);
    pme_pkg::cmd_t c;
    int            pick, fit;
    c.pos_a      = FW'($urandom_range(0, 31));
    c.pos_b      = FW'($urandom_range(0, 31));
    c.amount     = FW'($urandom_range(0, 31));
    c.load_value = FW'($urandom_range(0, 31));
    pick         = $urandom_range(0, 99);
    if (pick < 12) begin
      c.action = pme_pkg::ACT_LOAD;
    end else if (pick < 24) begin
      c.action = pme_pkg::ACT_READ;
    end else if (pick < 40) begin
      c.action = pme_pkg::ACT_SWAP;
    end else if (pick < 55) begin
      c.action = pme_pkg::ACT_ROTATE;
      if ($urandom_range(0, 4) != 0) c.amount = FW'($urandom_range(0, n - 1));
    end else if (pick < 75) begin
      c.action = pme_pkg::ACT_BLOCK;
      if ($urandom_range(0, 4) != 0) begin
        c.amount = FW'($urandom_range(1, n / 2));
        fit      = n / int'(c.amount);
        c.pos_a  = FW'($urandom_range(0, fit - 1));
        c.pos_b  = FW'($urandom_range(0, fit - 1));
      end
    end else if (pick < 95) begin
      c.action = pme_pkg::ACT_REVERSE;
      if ($urandom_range(0, 4) != 0)
        c.amount = FW'($urandom_range(0, (n > 31) ? 31 : n));
    end else begin
      c.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps between them.
  // A new request is only presented once the previous one has gone.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!cmd_valid || cmd_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd       <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // about a third of bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response sink: the stall pattern is redrawn whenever sink_cycle wraps, among
  // always ready, random drops, a fixed 5-in-8 ready duty, and long holds.
  // --------------------------------------------------------------------------
  int       stall_mode = 0;
  int       hold_left  = 0;
  bit [6:0] sink_cycle = '0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      sink_cycle++;
      if (sink_cycle == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 2) != 0);
        2: rsp_ready <= (sink_cycle[2:0] >= 3);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
          end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts on each accepted request and
  // checks each accepted response against the oldest prediction. The
  // response is checked before the same-edge request is predicted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pme_pkg::rsp_t want;
    pme_pkg::rsp_t owed;
    if (rst) begin
      model_count = pme_pkg::CITY_COUNT_RST;
      for (int i = 0; i < NCITIES; i++) perm_model[i] = VW'(i);
      expected_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) model_count = cfg_data;
      if (rsp_valid && rsp_ready) begin
        checked_count++;
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("response %0d/%0d with no request outstanding",
                                    rsp.read_value, rsp.status));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d (response %0d)",
                                      rsp.read_value, want.read_value, checked_count));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d (response %0d)",
                                      rsp.status, want.status, checked_count));
        end
      end
      if (cmd_valid && cmd_ready) begin
        accepted_count++;
        owed         = apply_mutation(cmd);
        expected_rsp = {expected_rsp, owed};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input logic [2:0] act, input int pa, input int pb,
                           input int amt, input int lv);
    pme_pkg::cmd_t c;
    c.action     = act;
    c.pos_a      = FW'(pa);
    c.pos_b      = FW'(pb);
    c.amount     = FW'(amt);
    c.load_value = FW'(lv);
    pending_cmds = {pending_cmds, c};
  endtask

  // Sender holds off until every request has been answered.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_rsp.size() != 0);
  endtask

  // Only called while idle, so the predictor sees the new count in order.
  task automatic write_city_count(input logic [CW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_settings++;
  endtask

  initial begin
    logic [CW-1:0] count_plan [9];
    int            n;

    // extremes, out-of-range counts that saturate, a middle value, reset value, random
    count_plan = '{6'd4, 6'd32, 6'd0, 6'd63, 6'd3, 6'd33, 6'd17, 6'd30, 6'd0};
    count_plan[8] = CW'($urandom_range(0, 63));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset count of 30; the engine is still
    // clearing its store for a while, so these simply wait for ready.
    queue_cmd(pme_pkg::ACT_READ,     0,  0,  0,  0);
    queue_cmd(pme_pkg::ACT_READ,    31, 31, 31, 31);  // 31 mod 30 -> entry 1
    queue_cmd(pme_pkg::ACT_LOAD,    29,  0,  0, 31);
    queue_cmd(pme_pkg::ACT_LOAD,    31, 31, 31,  0);
    queue_cmd(pme_pkg::ACT_SWAP,     3,  3,  0,  0);  // same position twice
    queue_cmd(pme_pkg::ACT_SWAP,     0, 29,  0,  0);
    queue_cmd(pme_pkg::ACT_ROTATE,   5,  0,  0,  0);  // zero distance
    queue_cmd(pme_pkg::ACT_ROTATE,   0,  0,  1,  0);
    queue_cmd(pme_pkg::ACT_ROTATE,   7,  0, 29,  0);  // largest legal distance
    queue_cmd(pme_pkg::ACT_ROTATE,   0,  0, 30,  0);  // distance equals count
    queue_cmd(pme_pkg::ACT_ROTATE,   0,  0, 31,  0);
    queue_cmd(pme_pkg::ACT_BLOCK,    0,  1,  0,  0);  // zero length
    queue_cmd(pme_pkg::ACT_BLOCK,    1,  1,  5,  0);  // same block
    queue_cmd(pme_pkg::ACT_BLOCK,    0,  5,  5,  0);  // second block ends at the count
    queue_cmd(pme_pkg::ACT_BLOCK,    0,  6,  5,  0);  // second block past the count
    queue_cmd(pme_pkg::ACT_BLOCK,    1,  0, 15,  0);  // two halves
    queue_cmd(pme_pkg::ACT_BLOCK,   31,  0, 31,  0);
    queue_cmd(pme_pkg::ACT_REVERSE,  4,  0,  0,  0);
    queue_cmd(pme_pkg::ACT_REVERSE,  4,  0,  1,  0);
    queue_cmd(pme_pkg::ACT_REVERSE, 28,  0,  5,  0);  // wraps past the end
    queue_cmd(pme_pkg::ACT_REVERSE, 29,  0,  2,  0);  // pair across the wrap
    queue_cmd(pme_pkg::ACT_REVERSE,  7,  0, 30,  0);  // whole active range
    queue_cmd(pme_pkg::ACT_REVERSE,  0,  0, 31,  0);  // longer than the count
    queue_cmd(ACT_SPARE_A,           2,  0,  0,  0);
    queue_cmd(ACT_SPARE_B,          31, 31, 31, 31);
    wait_idle();

    // Random phases, one per count setting, each run to completion first
    foreach (count_plan[k]) begin
      write_city_count(count_plan[k]);
      n = active_cities(count_plan[k]);
      @(negedge clk);
      for (int i = 0; i < ITEMS_PER_COUNT; i++)
        pending_cmds = {pending_cmds, random_mutation(n)};
      wait_idle();
    end

    // let any stray response show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_rsp.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));

    $display("Ran %0d requests over %0d city_count settings, %0d responses checked.",
             accepted_count, count_settings, checked_count);
    $display("Covered load, read, swap, rotate, block exchange, wrapping reverse and"
             , " bad actions; %0d mismatches.", error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
